FILE: rtl/ata_pio_host_sequencer_core_assert.svh
// Assertion macros for the ATA PIO host sequencer.
// Used by the top level; expects a clock named clk and a reset named rst.
`ifndef ATA_PIO_HOST_SEQUENCER_CORE_ASSERT_SVH
`define ATA_PIO_HOST_SEQUENCER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define APHS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("aphs assertion failed");

// Next-cycle implication, checked outside reset.
`define APHS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("aphs assertion failed");

`endif

FILE: rtl/aphs_pkg.sv
// Shared types, codes and helpers for the ATA PIO host sequencer.
// No dependencies.
`timescale 1ns / 1ps

package aphs_pkg;

  localparam int SECTOR_WORDS = 256;
  localparam int IDENT_WORDS  = 256;
  localparam int WORD_SPAN    = (SECTOR_WORDS > IDENT_WORDS) ? SECTOR_WORDS : IDENT_WORDS;
  localparam int IDX_W        = (WORD_SPAN > 1) ? $clog2(WORD_SPAN) : 1;

  localparam logic [IDX_W-1:0] SECTOR_LAST = IDX_W'(SECTOR_WORDS - 1);
  localparam logic [IDX_W-1:0] IDENT_LAST  = IDX_W'(IDENT_WORDS - 1);
  localparam logic [IDX_W-1:0] IDENT_CAP_LO = IDX_W'(60);
  localparam logic [IDX_W-1:0] IDENT_CAP_HI = IDX_W'(61);

  // Request codes
  localparam logic [2:0] OP_IDENTIFY = 3'd0;
  localparam logic [2:0] OP_READ     = 3'd1;
  localparam logic [2:0] OP_WRITE    = 3'd2;
  localparam logic [2:0] OP_REPLY    = 3'd3;
  localparam logic [2:0] OP_WORD     = 3'd4;
  localparam logic [2:0] OP_IRQ      = 3'd5;

  // Result kinds
  localparam logic [2:0] K_WRITE = 3'd0;
  localparam logic [2:0] K_DELAY = 3'd1;
  localparam logic [2:0] K_READ  = 3'd2;
  localparam logic [2:0] K_WORD  = 3'd3;
  localparam logic [2:0] K_DONE  = 3'd4;

  // Task-file ports
  localparam logic [3:0] P_DATA   = 4'd0;
  localparam logic [3:0] P_COUNT  = 4'd2;
  localparam logic [3:0] P_LBALO  = 4'd3;
  localparam logic [3:0] P_LBAMID = 4'd4;
  localparam logic [3:0] P_LBAHI  = 4'd5;
  localparam logic [3:0] P_SELECT = 4'd6;
  localparam logic [3:0] P_CMD    = 4'd7;
  localparam logic [3:0] P_CTRL   = 4'd8;

  // Device codes
  localparam logic [7:0] SEL_MASTER = 8'hE0;
  localparam logic [7:0] CMD_IDENT  = 8'hEC;
  localparam logic [7:0] CMD_READ   = 8'h20;
  localparam logic [7:0] CMD_WRITE  = 8'h30;
  localparam logic [7:0] CMD_FLUSH  = 8'hE7;
  localparam int ST_BSY = 7;
  localparam int ST_DF  = 5;
  localparam int ST_DRQ = 3;
  localparam int ST_ERR = 0;

  // Command issue burst: select, 4 delays, 5 writes, 4 delays, status read
  localparam logic [3:0] ISSUE_LAST = 4'd14;

  typedef struct packed {
    logic [2:0]  kind;
    logic [3:0]  port;
    logic [15:0] data;
    logic        ok;
  } result_t;

  typedef struct packed {
    logic        load;
    logic        issue;
    logic [1:0]  count_m1;
    result_t     r0;
    result_t     r1;
    result_t     r2;
    logic [7:0]  sel;
    logic [7:0]  count;
    logic [23:0] lba;
    logic [7:0]  cmd;
    logic        present;
    logic [31:0] capacity;
  } burst_t;

  typedef struct packed {
    logic        valid;
    logic        last;
    result_t     res;
    logic        present;
    logic [31:0] capacity;
  } beat_t;

  typedef struct packed {
    logic        present;
    logic [31:0] capacity;
    logic        idle;
  } status_t;

  function automatic result_t mk_result(input logic [2:0] kind, input logic [3:0] port,
                                        input logic [15:0] data, input logic ok);
    result_t r;
    r.kind = kind;
    r.port = port;
    r.data = data;
    r.ok   = ok;
    return r;
  endfunction

  function automatic result_t issue_result(input logic [3:0] beat, input logic [7:0] sel,
                                           input logic [7:0] count, input logic [23:0] lba,
                                           input logic [7:0] cmd);
    result_t r;
    case (beat)
      4'd0:    r = mk_result(K_WRITE, P_SELECT, {8'h00, sel}, 1'b0);
      4'd5:    r = mk_result(K_WRITE, P_COUNT, {8'h00, count}, 1'b0);
      4'd6:    r = mk_result(K_WRITE, P_LBALO, {8'h00, lba[7:0]}, 1'b0);
      4'd7:    r = mk_result(K_WRITE, P_LBAMID, {8'h00, lba[15:8]}, 1'b0);
      4'd8:    r = mk_result(K_WRITE, P_LBAHI, {8'h00, lba[23:16]}, 1'b0);
      4'd9:    r = mk_result(K_WRITE, P_CMD, {8'h00, cmd}, 1'b0);
      4'd14:   r = mk_result(K_READ, P_CMD, 16'h0000, 1'b0);
      default: r = mk_result(K_DELAY, P_CTRL, 16'h0000, 1'b0);
    endcase
    return r;
  endfunction

endpackage

FILE: rtl/aphs_if.sv
// Request and result channel interfaces of the ATA PIO host sequencer.
// No dependencies.
`timescale 1ns / 1ps

interface aphs_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [31:0] lba;
  logic [15:0] read_value;
  logic [15:0] write_word;

  modport source (output valid, operation, lba, read_value, write_word, input ready);
  modport sink (input valid, operation, lba, read_value, write_word, output ready);
endinterface

interface aphs_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [3:0]  port;
  logic [15:0] bus_data;
  logic        success;
  logic        drive_present;
  logic [31:0] sector_total;
  logic        last;

  modport source (output valid, kind, port, bus_data, success, drive_present,
                  sector_total, last, input ready);
  modport sink (input valid, kind, port, bus_data, success, drive_present,
                sector_total, last, output ready);
endinterface

FILE: rtl/ata_pio_host_sequencer_core.sv
// Top level of the ATA PIO host sequencer (primary channel, master drive).
// Depends on aphs_pkg, aphs_if, aphs_seq, aphs_emit and the assertion header.
//
//   channel  direction  transfer carries
//   req      in         operation, lba, read_value, write_word
//   rsp      out        kind, port, bus_data, success, drive_present,
//                       sector_total, last
//
// Each request transfer is handled in the cycle it is taken: the phase,
// presence, capacity and word index update at that edge and the results
// it causes are held as one burst in the result register.
// The burst leaves one result per cycle while rsp is ready: 15 for a command issue,
// 1 to 3 otherwise, so a request waits until the previous burst has drained.
// A new request is taken in the cycle the previous burst's final result
// transfers, so requests follow back to back behind the output.
// rsp stalls hold the burst in place; on its final result req.ready follows rsp.ready.
// Reset (rst, synchronous) returns to idle with no drive and zero capacity.
`timescale 1ns / 1ps
`include "ata_pio_host_sequencer_core_assert.svh"

module ata_pio_host_sequencer_core import aphs_pkg::*; (
  input logic       clk,
  input logic       rst,
  aphs_req_if.sink  req,
  aphs_rsp_if.source rsp
);

  logic    accept;
  logic    free;
  burst_t  burst;
  status_t status;
  beat_t   beat_out;

  // Take a request whenever the result stage can load a new burst
  assign req.ready = free;
  assign accept    = req.valid && req.ready;

  aphs_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .operation  (req.operation),
    .lba        (req.lba),
    .read_value (req.read_value),
    .write_word (req.write_word),
    .burst      (burst),
    .status     (status)
  );

  aphs_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .burst     (burst),
    .out_ready (rsp.ready),
    .free      (free),
    .beat_out  (beat_out)
  );

  // Drive the result channel from the current beat
  assign rsp.valid         = beat_out.valid;
  assign rsp.kind          = beat_out.res.kind;
  assign rsp.port          = beat_out.res.port;
  assign rsp.bus_data      = beat_out.res.data;
  assign rsp.success       = beat_out.res.ok;
  assign rsp.drive_present = beat_out.present;
  assign rsp.sector_total  = beat_out.capacity;
  assign rsp.last          = beat_out.last;

  // No request may slip in while a burst still has results after this one
  `APHS_ASSERT_IMP(a_no_accept_mid_burst, rsp.valid && !rsp.last, !req.ready)

  // Reported presence and capacity track the live state
  `APHS_ASSERT_IMP(a_status_match, rsp.valid,
                   rsp.drive_present == status.present && rsp.sector_total == status.capacity)

  // A finished result closes its burst and leaves the sequencer idle
  `APHS_ASSERT_IMP(a_done_last, rsp.valid && rsp.kind == K_DONE,
                   rsp.last && rsp.port == P_DATA && status.idle)

  // A final transfer with no new request leaves the output empty
  `APHS_ASSERT_NEXT(a_drain, rsp.valid && rsp.ready && rsp.last && !accept, !rsp.valid)

endmodule

FILE: rtl/aphs_seq.sv
// Protocol state of the sequencer: phase, presence, capacity, word index.
// Depends on aphs_pkg. Builds the result burst for each accepted request.
`timescale 1ns / 1ps

module aphs_seq import aphs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [2:0]  operation,
  input  logic [31:0] lba,
  input  logic [15:0] read_value,
  input  logic [15:0] write_word,
  output burst_t      burst,
  output status_t     status
);

  localparam logic [3:0] PH_IDLE      = 4'd0;
  localparam logic [3:0] PH_ID_FIRST  = 4'd1;
  localparam logic [3:0] PH_ID_POLL   = 4'd2;
  localparam logic [3:0] PH_MID_ERR   = 4'd3;
  localparam logic [3:0] PH_MID_DRQ   = 4'd4;
  localparam logic [3:0] PH_MID_NONE  = 4'd5;
  localparam logic [3:0] PH_HIGH_ERR  = 4'd6;
  localparam logic [3:0] PH_HIGH_DRQ  = 4'd7;
  localparam logic [3:0] PH_HIGH_NONE = 4'd8;
  localparam logic [3:0] PH_ID_WAIT   = 4'd9;
  localparam logic [3:0] PH_ID_DATA   = 4'd10;
  localparam logic [3:0] PH_RD_POLL   = 4'd11;
  localparam logic [3:0] PH_RD_DATA   = 4'd12;
  localparam logic [3:0] PH_WR_POLL   = 4'd13;
  localparam logic [3:0] PH_WR_DATA   = 4'd14;
  localparam logic [3:0] PH_WR_FLUSH  = 4'd15;

  logic [3:0]       phase, phase_next;
  logic             present, present_next;
  logic [31:0]      capacity, capacity_next;
  logic [IDX_W-1:0] word_index, word_index_next;
  logic [15:0]      cap_low, cap_low_next;

  logic [7:0] s;
  logic       do_fail;
  logic       do_start;
  logic [1:0] nres;
  result_t    r0, r1, r2;

  assign s = read_value[7:0];

  always_comb begin
    phase_next      = phase;
    present_next    = present;
    capacity_next   = capacity;
    word_index_next = word_index;
    cap_low_next    = cap_low;
    do_fail  = 1'b0;
    do_start = 1'b0;
    nres     = 2'd0;
    r0 = mk_result(K_DONE, P_DATA, 16'h0000, 1'b0);
    r1 = r0;
    r2 = r0;
    burst = '0;
    if (accept) begin
      case (operation)
        OP_IDENTIFY, OP_READ, OP_WRITE: begin
          if (phase == PH_IDLE) begin
            if (operation == OP_IDENTIFY) begin
              burst.issue = 1'b1;
              burst.sel   = SEL_MASTER;
              burst.count = 8'h00;
              burst.lba   = 24'h000000;
              burst.cmd   = CMD_IDENT;
              phase_next  = PH_ID_FIRST;
            end else if (!present || lba >= capacity) begin
              nres = 2'd1;
            end else begin
              burst.issue = 1'b1;
              burst.sel   = SEL_MASTER | {4'h0, lba[27:24]};
              burst.count = 8'h01;
              burst.lba   = lba[23:0];
              burst.cmd   = (operation == OP_READ) ? CMD_READ : CMD_WRITE;
              phase_next  = (operation == OP_READ) ? PH_RD_POLL : PH_WR_POLL;
            end
          end
        end
        OP_REPLY: begin
          case (phase)
            PH_ID_FIRST: begin
              if (s == 8'h00) begin
                do_fail = 1'b1;
              end else begin
                phase_next = PH_ID_POLL;
                nres = 2'd1;
                r0 = mk_result(K_READ, P_CMD, 16'h0000, 1'b0);
              end
            end
            PH_ID_POLL: begin
              nres = 2'd1;
              if (s[ST_BSY]) begin
                r0 = mk_result(K_READ, P_CMD, 16'h0000, 1'b0);
              end else begin
                r0 = mk_result(K_READ, P_LBAMID, 16'h0000, 1'b0);
                if (s[ST_ERR]) phase_next = PH_MID_ERR;
                else if (s[ST_DRQ]) phase_next = PH_MID_DRQ;
                else phase_next = PH_MID_NONE;
              end
            end
            PH_MID_ERR, PH_MID_DRQ, PH_MID_NONE: begin
              if (s != 8'h00) begin
                do_fail = 1'b1;
              end else begin
                nres = 2'd1;
                r0 = mk_result(K_READ, P_LBAHI, 16'h0000, 1'b0);
                if (phase == PH_MID_ERR) phase_next = PH_HIGH_ERR;
                else if (phase == PH_MID_DRQ) phase_next = PH_HIGH_DRQ;
                else phase_next = PH_HIGH_NONE;
              end
            end
            PH_HIGH_ERR, PH_HIGH_DRQ, PH_HIGH_NONE: begin
              if (s != 8'h00 || phase == PH_HIGH_ERR) begin
                do_fail = 1'b1;
              end else if (phase == PH_HIGH_DRQ) begin
                do_start = 1'b1;
              end else begin
                phase_next = PH_ID_WAIT;
                nres = 2'd1;
                r0 = mk_result(K_READ, P_CMD, 16'h0000, 1'b0);
              end
            end
            PH_ID_WAIT: begin
              if (s[ST_ERR]) begin
                do_fail = 1'b1;
              end else if (s[ST_DRQ]) begin
                do_start = 1'b1;
              end else begin
                nres = 2'd1;
                r0 = mk_result(K_READ, P_CMD, 16'h0000, 1'b0);
              end
            end
            PH_ID_DATA: begin
              if (word_index == IDENT_CAP_LO) cap_low_next = read_value;
              else if (word_index == IDENT_CAP_HI) capacity_next = {read_value, cap_low};
              word_index_next = word_index + 1'b1;
              nres = 2'd1;
              if (word_index == IDENT_LAST) begin
                present_next = 1'b1;
                phase_next   = PH_IDLE;
                r0 = mk_result(K_DONE, P_DATA, 16'h0000, 1'b1);
              end else begin
                r0 = mk_result(K_READ, P_DATA, 16'h0000, 1'b0);
              end
            end
            PH_RD_POLL, PH_WR_POLL: begin
              if (s[ST_BSY]) begin
                nres = 2'd1;
                r0 = mk_result(K_READ, P_CMD, 16'h0000, 1'b0);
              end else if (s[ST_ERR] || s[ST_DF] || !s[ST_DRQ]) begin
                nres = 2'd1;
                phase_next = PH_IDLE;
              end else begin
                word_index_next = '0;
                if (phase == PH_WR_POLL) begin
                  phase_next = PH_WR_DATA;
                end else begin
                  phase_next = PH_RD_DATA;
                  nres = 2'd1;
                  r0 = mk_result(K_READ, P_DATA, 16'h0000, 1'b0);
                end
              end
            end
            PH_RD_DATA: begin
              nres = 2'd2;
              r0 = mk_result(K_WORD, P_DATA, read_value, 1'b0);
              word_index_next = word_index + 1'b1;
              if (word_index == SECTOR_LAST) begin
                phase_next = PH_IDLE;
                r1 = mk_result(K_DONE, P_DATA, 16'h0000, 1'b1);
              end else begin
                r1 = mk_result(K_READ, P_DATA, 16'h0000, 1'b0);
              end
            end
            PH_WR_FLUSH: begin
              nres = 2'd1;
              if (s[ST_BSY]) begin
                r0 = mk_result(K_READ, P_CMD, 16'h0000, 1'b0);
              end else begin
                phase_next = PH_IDLE;
                r0 = mk_result(K_DONE, P_DATA, 16'h0000, 1'b1);
              end
            end
            default: ;
          endcase
        end
        OP_WORD: begin
          if (phase == PH_WR_DATA) begin
            nres = 2'd1;
            r0 = mk_result(K_WRITE, P_DATA, write_word, 1'b0);
            word_index_next = word_index + 1'b1;
            if (word_index == SECTOR_LAST) begin
              nres = 2'd3;
              r1 = mk_result(K_WRITE, P_CMD, {8'h00, CMD_FLUSH}, 1'b0);
              r2 = mk_result(K_READ, P_CMD, 16'h0000, 1'b0);
              phase_next = PH_WR_FLUSH;
            end
          end
        end
        OP_IRQ: begin
          nres = 2'd1;
          r0 = mk_result(K_DELAY, P_CMD, 16'h0000, 1'b0);
        end
        default: ;
      endcase
    end

    // Identify failure: drop presence, finish unsuccessfully
    if (do_fail) begin
      present_next = 1'b0;
      phase_next   = PH_IDLE;
      nres = 2'd1;
      r0 = mk_result(K_DONE, P_DATA, 16'h0000, 1'b0);
    end
    // Identify data phase: start reading words from zero
    if (do_start) begin
      word_index_next = '0;
      phase_next      = PH_ID_DATA;
      nres = 2'd1;
      r0 = mk_result(K_READ, P_DATA, 16'h0000, 1'b0);
    end

    burst.load     = burst.issue || (nres != 2'd0);
    burst.count_m1 = nres - 2'd1;
    burst.r0       = r0;
    burst.r1       = r1;
    burst.r2       = r2;
    burst.present  = present_next;
    burst.capacity = capacity_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      present    <= 1'b0;
      capacity   <= '0;
      word_index <= '0;
    end else begin
      phase      <= phase_next;
      present    <= present_next;
      capacity   <= capacity_next;
      word_index <= word_index_next;
    end
  end

  always_ff @(posedge clk) begin
    cap_low <= cap_low_next;
  end

  assign status.present  = present;
  assign status.capacity = capacity;
  assign status.idle     = (phase == PH_IDLE);

endmodule

FILE: rtl/aphs_emit.sv
// Result register and beat counter: streams one burst as single results.
// Depends on aphs_pkg.
`timescale 1ns / 1ps

module aphs_emit import aphs_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   accept,
  input  burst_t burst,
  input  logic   out_ready,
  output logic   free,
  output beat_t  beat_out
);

  logic       busy;
  logic [3:0] beat;
  burst_t     desc;
  logic [3:0] beat_last;
  logic       last_beat;
  result_t    cur;

  assign beat_last = desc.issue ? ISSUE_LAST : {2'b00, desc.count_m1};
  assign last_beat = (beat == beat_last);
  assign free      = !busy || (out_ready && last_beat);

  always_comb begin
    if (desc.issue) begin
      cur = issue_result(beat, desc.sel, desc.count, desc.lba, desc.cmd);
    end else begin
      case (beat[1:0])
        2'd1:    cur = desc.r1;
        2'd2:    cur = desc.r2;
        default: cur = desc.r0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      beat <= '0;
    end else if (accept && burst.load) begin
      busy <= 1'b1;
      beat <= '0;
    end else if (busy && out_ready) begin
      if (last_beat) busy <= 1'b0;
      else beat <= beat + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && burst.load) desc <= burst;
  end

  assign beat_out.valid    = busy;
  assign beat_out.last     = last_beat;
  assign beat_out.res      = cur;
  assign beat_out.present  = desc.present;
  assign beat_out.capacity = desc.capacity;

endmodule
